// ----- rtl/gpio_port_with_edge_interrupts_assert.svh -----
// assertion macros for the gpio port with edge interrupts
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef GPIO_PORT_WITH_EDGE_INTERRUPTS_ASSERT_SVH
`define GPIO_PORT_WITH_EDGE_INTERRUPTS_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GPIO_ASSERT_NOW(label, ante, cons, msg) \
label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define GPIO_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gpio_pkg.sv -----
// shared types and constants for the gpio port with edge interrupts
// no dependencies
package gpio_pkg;

    localparam int PIN_COUNT = 8;
    localparam int PIN_W     = $clog2(PIN_COUNT);
    localparam int ADDR_W    = 20;
    localparam int VEC_W     = 6;
    localparam int REG_COUNT = 8;
    localparam int REG_W     = $clog2(REG_COUNT);

    // register file layout
    localparam logic [REG_W-1:0] REG_IN  = 3'd0;
    localparam logic [REG_W-1:0] REG_OUT = 3'd1;
    localparam logic [REG_W-1:0] REG_DIR = 3'd2;
    localparam logic [REG_W-1:0] REG_IFG = 3'd3;
    localparam logic [REG_W-1:0] REG_IES = 3'd4;
    localparam logic [REG_W-1:0] REG_IE  = 3'd5;
    localparam logic [REG_W-1:0] REG_SEL = 3'd6;
    localparam logic [REG_W-1:0] REG_REN = 3'd7;

    // configuration register indexes
    localparam logic [1:0] CFG_BASE   = 2'd0;
    localparam logic [1:0] CFG_IRQ_EN = 2'd1;
    localparam logic [1:0] CFG_VECTOR = 2'd2;

    // reset value of the base address and the fixed part of the pull-enable address
    localparam logic [ADDR_W-1:0] BASE_RESET = 20'h00020;
    localparam logic [ADDR_W-1:0] PULL_BASE  = 20'h00010;

    typedef enum logic [1:0] {
        MODE_READ     = 2'd0,
        MODE_WRITE    = 2'd1,
        MODE_PIN      = 2'd2,
        MODE_SOFT_RST = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode                 mode;
        logic [ADDR_W-1:0]     bus_address;
        logic [PIN_COUNT-1:0]  write_data;
        logic [PIN_W-1:0]      pin_index;
        logic                  pin_level;
    } t_in_item;

    typedef struct packed {
        logic [PIN_COUNT-1:0]  read_data;
        logic                  read_hit;
        logic                  irq_request;
        logic [VEC_W-1:0]      irq_number;
    } t_out_item;

    // address decode result passed to the register file
    typedef struct packed {
        logic              hit;
        logic              above_base;
        logic [REG_W-1:0]  idx;
    } t_dec;

endpackage

// ----- rtl/gpio_decode.sv -----
// bus address decode for both register maps
// depends on gpio_pkg
module gpio_decode
    import gpio_pkg::*;
(
    input  logic [ADDR_W-1:0] i_base,
    input  logic              i_irq_en,
    input  logic [ADDR_W-1:0] i_addr,
    output t_dec              o_dec
);

    logic [ADDR_W:0]   w_diff;
    logic              w_ge;
    logic [ADDR_W-1:0] w_pull_addr;

    // offset from base, one extra bit so a negative offset shows
    assign w_diff = {1'b0, i_addr} - {1'b0, i_base};
    assign w_ge   = !w_diff[ADDR_W];

    // pull-enable address of the reduced map
    assign w_pull_addr = PULL_BASE | {{(ADDR_W-2){1'b0}}, i_base[5], i_base[2]};

    // map selection, earlier match wins
    always_comb begin
        o_dec.above_base = w_ge;
        o_dec.hit        = 1'b0;
        o_dec.idx        = w_diff[REG_W-1:0];
        if (i_irq_en) begin
            o_dec.hit = w_ge && (w_diff[ADDR_W-1:REG_W] == '0);
        end else if (w_ge && (w_diff <= (ADDR_W+1)'(2))) begin
            o_dec.hit = 1'b1;
        end else if (w_ge && (w_diff == (ADDR_W+1)'(3))) begin
            o_dec.hit = 1'b1;
            o_dec.idx = REG_SEL;
        end else if (i_addr == w_pull_addr) begin
            o_dec.hit = 1'b1;
            o_dec.idx = REG_REN;
        end
    end

endmodule

// ----- rtl/gpio_regs.sv -----
// port register file with bus access, pin edge detection and soft reset
// depends on gpio_pkg
module gpio_regs
    import gpio_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_in_item         i_item,
    input  t_dec             i_dec,
    input  logic             i_irq_en,
    input  logic [VEC_W-1:0] i_vector,
    output t_out_item        o_res
);

    logic [PIN_COUNT-1:0] r_regs [REG_COUNT];
    logic [PIN_COUNT-1:0] n_regs [REG_COUNT];
    logic [PIN_COUNT-1:0] w_mask;
    logic                 w_was_high;
    logic                 w_fall_sel;
    logic                 w_edge;
    logic                 w_req;

    // pin change edge detection
    assign w_mask     = PIN_COUNT'(1) << i_item.pin_index;
    assign w_was_high = |(r_regs[REG_IN] & w_mask);
    assign w_fall_sel = |(r_regs[REG_IES] & w_mask);
    assign w_edge     = (|(r_regs[REG_IE] & w_mask)) &&
                        ((w_fall_sel && !i_item.pin_level && w_was_high) ||
                         (!w_fall_sel && i_item.pin_level && !w_was_high));

    // next register contents
    always_comb begin
        n_regs = r_regs;
        case (i_item.mode)
            MODE_READ: begin
            end
            MODE_WRITE: begin
                if (i_dec.hit) begin
                    n_regs[i_dec.idx] = i_item.write_data;
                end
            end
            MODE_PIN: begin
                if (w_edge) begin
                    n_regs[REG_IFG] = r_regs[REG_IFG] | w_mask;
                end
                if (i_item.pin_level) begin
                    n_regs[REG_IN] = r_regs[REG_IN] | w_mask;
                end else begin
                    n_regs[REG_IN] = r_regs[REG_IN] & ~w_mask;
                end
            end
            MODE_SOFT_RST: begin
                n_regs[REG_DIR] = '0;
                n_regs[REG_IFG] = '0;
                n_regs[REG_IE]  = '0;
                n_regs[REG_SEL] = '0;
                n_regs[REG_REN] = '0;
            end
            default: begin
            end
        endcase
    end

    // result of the transfer, request taken after the update
    assign w_req = i_irq_en && (|(n_regs[REG_IFG] & n_regs[REG_IE]));

    always_comb begin
        o_res = '0;
        if ((i_item.mode == MODE_READ) && i_dec.hit && i_dec.above_base) begin
            o_res.read_data = r_regs[i_dec.idx];
            o_res.read_hit  = 1'b1;
        end
        o_res.irq_request = w_req;
        o_res.irq_number  = w_req ? i_vector : '0;
    end

    // register update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= '0;
            end
        end else if (i_en) begin
            r_regs <= n_regs;
        end
    end

endmodule

// ----- rtl/gpio_port_with_edge_interrupts.sv -----
// top level of the gpio port with edge interrupts: handshakes, configuration, result register
// depends on gpio_pkg, gpio_decode, gpio_regs and the assertion macro header
//
// Eight-pin IO port behind byte registers. Every transfer on the input channel is a bus
// read, a bus write, a pin level change or a soft reset, and gives exactly one result
// carrying the read byte, the hit flag and the interrupt request with its vector. One
// transfer is taken every clock cycle unless the input is stalled; each transfer passes
// through the input register and then the result register, with the decode and register
// update done between them. A stall on the output holds the result register and, once
// the input register is also full, stalls the input. Configuration writes (base address,
// map select, vector) take effect the next cycle; the user must make them only while
// the port is idle, and the block itself does not enforce this.
`include "gpio_port_with_edge_interrupts_assert.svh"

module gpio_port_with_edge_interrupts
    import gpio_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [ADDR_W-1:0] i_cfg_data
);

    logic              r_in_valid;
    t_in_item          r_in;
    logic              r_out_valid;
    t_out_item         r_out;
    logic [ADDR_W-1:0] r_base;
    logic              r_irq_en;
    logic [VEC_W-1:0]  r_vector;

    logic              w_out_block;
    logic              w_adv;
    t_dec              w_dec;
    t_out_item         w_res;

    // flow control between the two register stages
    assign w_out_block = r_out_valid && i_out_stall;
    assign w_adv       = r_in_valid && !w_out_block;
    assign o_in_stall  = r_in_valid && w_out_block;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= BASE_RESET;
            r_irq_en <= 1'b0;
            r_vector <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE:   r_base   <= i_cfg_data;
                CFG_IRQ_EN: r_irq_en <= i_cfg_data[0];
                CFG_VECTOR: r_vector <= i_cfg_data[VEC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
    end

    // address decode
    gpio_decode u_decode (
        .i_base   (r_base),
        .i_irq_en (r_irq_en),
        .i_addr   (r_in.bus_address),
        .o_dec    (w_dec)
    );

    // register file and result
    gpio_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_item   (r_in),
        .i_dec    (w_dec),
        .i_irq_en (r_irq_en),
        .i_vector (r_vector),
        .o_res    (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // checks
    `GPIO_ASSERT_NEXT(a_adv_fills_out, w_adv, r_out_valid, "advanced item missing from result register")
    `GPIO_ASSERT_NOW(a_full_blocked_stalls, r_in_valid && w_out_block, o_in_stall, "input not stalled while both stages are full")
    `GPIO_ASSERT_NOW(a_vec_needs_req, o_out_valid && !o_out.irq_request, o_out.irq_number == '0, "vector reported without a request")
    `GPIO_ASSERT_NOW(a_miss_reads_zero, o_out_valid && !o_out.read_hit, o_out.read_data == '0, "read data on a missed read")

endmodule
